FILE: rtl/bezval_pkg.sv
// shared constants for the bezier segment value unit
package bezval_pkg;

    localparam int IN_W  = 216;
    localparam int OUT_W = 40;

    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [63:0] SLOPE_MIN = 64'd1100;
    localparam logic signed [31:0] VAL_MIN = -32'sd262144;
    localparam logic signed [31:0] VAL_MAX = 32'sd262143;
    localparam logic signed [63:0] ROUND_HALF = 64'sd2147483648;

    typedef logic signed [62:0] prod_t;
    typedef logic signed [63:0] acc_t;

endpackage

FILE: rtl/bezier_segment_value_at_x.sv
// bezier segment value at x: newton solve of the x cubic, then value cubic evaluation
//
// One request carries a cubic segment and an x fraction; the block answers with the curve
// value and the solved parameter. Everything runs on one signed 27x36 multiplier with a
// registered product and a 64 bit accumulator, plus a 64 bit restoring divider (one quotient
// bit per cycle) for the newton correction. Each newton step runs the divider unless its
// correction caps at two, in which case the divider is skipped; at most NEWTON_STEPS steps
// run, and the solve stops early on the error or slope test. The finished result may then
// wait for the output register. s_axis_tready is high only while idle; a finished result
// waits in the output register while the next request is taken.
module bezier_segment_value_at_x
    import bezval_pkg::*;
#(
    parameter int NEWTON_STEPS = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // fraction_t, start_beat, end_beat, out_handle_beat, in_handle_beat,
    // start_value, end_value, out_handle_value, in_handle_value
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // curve_value, solved_param
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam int CW = $clog2(NEWTON_STEPS + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_N_MM  = 5'd1;
    localparam logic [4:0] ST_N_SS  = 5'd2;
    localparam logic [4:0] ST_N_R   = 5'd3;
    localparam logic [4:0] ST_N_B1  = 5'd4;
    localparam logic [4:0] ST_N_B2  = 5'd5;
    localparam logic [4:0] ST_N_B3  = 5'd6;
    localparam logic [4:0] ST_N_E1  = 5'd7;
    localparam logic [4:0] ST_N_E2  = 5'd8;
    localparam logic [4:0] ST_N_E3  = 5'd9;
    localparam logic [4:0] ST_N_E4  = 5'd10;
    localparam logic [4:0] ST_N_S1  = 5'd11;
    localparam logic [4:0] ST_N_S2  = 5'd12;
    localparam logic [4:0] ST_N_S3  = 5'd13;
    localparam logic [4:0] ST_N_WT  = 5'd14;
    localparam logic [4:0] ST_N_MAG = 5'd15;
    localparam logic [4:0] ST_N_TST = 5'd16;
    localparam logic [4:0] ST_N_D0  = 5'd17;
    localparam logic [4:0] ST_N_DIV = 5'd18;
    localparam logic [4:0] ST_N_UPD = 5'd19;
    localparam logic [4:0] ST_V_MM  = 5'd20;
    localparam logic [4:0] ST_V_SS  = 5'd21;
    localparam logic [4:0] ST_V_W0  = 5'd22;
    localparam logic [4:0] ST_V_W1  = 5'd23;
    localparam logic [4:0] ST_V_W2  = 5'd24;
    localparam logic [4:0] ST_V_W3  = 5'd25;
    localparam logic [4:0] ST_V_A0  = 5'd26;
    localparam logic [4:0] ST_V_A1  = 5'd27;
    localparam logic [4:0] ST_V_A2  = 5'd28;
    localparam logic [4:0] ST_V_A3  = 5'd29;
    localparam logic [4:0] ST_V_WT  = 5'd30;
    localparam logic [4:0] ST_V_FIN = 5'd31;

    localparam logic [3:0] DST_NONE = 4'd0;
    localparam logic [3:0] DST_P    = 4'd1;
    localparam logic [3:0] DST_Q    = 4'd2;
    localparam logic [3:0] DST_R    = 4'd3;
    localparam logic [3:0] DST_B1   = 4'd4;
    localparam logic [3:0] DST_B2   = 4'd5;
    localparam logic [3:0] DST_B3   = 4'd6;
    localparam logic [3:0] DST_ESET = 4'd7;
    localparam logic [3:0] DST_EADD = 4'd8;
    localparam logic [3:0] DST_ESUB = 4'd9;
    localparam logic [3:0] DST_SSET = 4'd10;
    localparam logic [3:0] DST_SADD = 4'd11;
    localparam logic [3:0] DST_W0   = 4'd12;
    localparam logic [3:0] DST_W1   = 4'd13;
    localparam logic [3:0] DST_W2   = 4'd14;
    localparam logic [3:0] DST_W3   = 4'd15;

    logic [4:0]     state_reg, state_next;
    logic [3:0]     dst_reg, dst_next;
    logic [CW-1:0]  cnt_reg;
    logic [3:0]     div_cnt_reg;
    logic           out_valid_reg;

    logic [15:0]        t_reg;
    logic signed [32:0] dx_reg;
    logic signed [31:0] d1_reg;
    logic signed [31:0] ih_reg;
    logic signed [18:0] v0_reg, v3_reg, c1_reg, c2_reg;
    logic [16:0]        s_reg;

    prod_t              prod_reg;
    logic [32:0]        p_reg, q_reg;
    logic [24:0]        b1_reg, b2_reg, b3_reg;
    logic [25:0]        a0_reg, a1_reg, a2_reg;
    logic [32:0]        w0_reg, w1_reg, w2_reg, w3_reg;
    acc_t               err_reg, slope_reg;
    logic [63:0]        emag_reg, smag_reg, rem_reg;
    logic               neg_reg, qi_reg, two_reg;
    logic [15:0]        frac_reg;
    logic signed [18:0] value_reg;
    logic [16:0]        solved_reg;

    logic signed [26:0] mul_a;
    logic signed [35:0] mul_b;
    logic [16:0]        ms;
    logic [18:0]        s3, ms3;
    logic signed [33:0] d2;
    logic signed [34:0] dd;
    logic signed [32:0] nih;
    logic [34:0]        three_p;
    logic [33:0]        six_r;
    acc_t               prod_ext, prod_sh8, tol_base, tol, rnd;
    logic [63:0]        rem2;
    logic               in_fire;
    logic signed [18:0] s_upd;
    logic [17:0]        delta;
    logic signed [31:0] vq;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, solved_reg, value_reg};

    assign ms   = ONE_Q16 - s_reg;
    assign s3   = {2'd0, s_reg} + {1'b0, s_reg, 1'b0};
    assign ms3  = {2'd0, ms} + {1'b0, ms, 1'b0};
    assign d2   = $signed({dx_reg[32], dx_reg}) + $signed({{2{ih_reg[31]}}, ih_reg});
    assign dd   = $signed({d2[33], d2}) - $signed({{3{d1_reg[31]}}, d1_reg});
    assign nih  = -$signed({ih_reg[31], ih_reg});

    assign three_p  = {2'd0, prod_reg[32:0]} + {1'b0, prod_reg[32:0], 1'b0};
    assign six_r    = {1'b0, prod_reg[30:0], 2'd0} + {2'd0, prod_reg[30:0], 1'b0};
    assign prod_ext = {prod_reg[62], prod_reg};
    assign prod_sh8 = {prod_reg[55:0], 8'd0};
    assign tol_base = $signed({{31{dx_reg[32]}}, dx_reg}) + 64'sd65536;
    assign tol      = $signed({tol_base[59:0], 4'd0}) + tol_base;
    assign rem2     = {rem_reg[62:0], 1'b0};
    assign delta    = two_reg ? 18'd131072 : {1'b0, qi_reg, frac_reg};
    assign s_upd    = neg_reg ? $signed({2'd0, s_reg}) + $signed({1'b0, delta})
                              : $signed({2'd0, s_reg}) - $signed({1'b0, delta});
    assign rnd      = err_reg + ROUND_HALF;
    assign vq       = rnd[63:32];

    // sequencer: operand select and next state
    always_comb
    begin
        state_next = state_reg;
        dst_next   = DST_NONE;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_N_MM;
                end
            end
            ST_N_MM, ST_V_MM:
            begin
                mul_a = $signed({10'd0, ms});
                mul_b = $signed({19'd0, ms});
                dst_next = DST_P;
                state_next = (state_reg == ST_N_MM) ? ST_N_SS : ST_V_SS;
            end
            ST_N_SS, ST_V_SS:
            begin
                mul_a = $signed({10'd0, s_reg});
                mul_b = $signed({19'd0, s_reg});
                dst_next = DST_Q;
                state_next = (state_reg == ST_N_SS) ? ST_N_R : ST_V_W0;
            end
            ST_N_R:
            begin
                mul_a = $signed({10'd0, ms});
                mul_b = $signed({19'd0, s_reg});
                dst_next = DST_R;
                state_next = ST_N_B1;
            end
            ST_N_B1:
            begin
                mul_a = $signed({8'd0, s3});
                mul_b = $signed({3'd0, p_reg});
                dst_next = DST_B1;
                state_next = ST_N_B2;
            end
            ST_N_B2:
            begin
                mul_a = $signed({8'd0, ms3});
                mul_b = $signed({3'd0, q_reg});
                dst_next = DST_B2;
                state_next = ST_N_B3;
            end
            ST_N_B3:
            begin
                mul_a = $signed({10'd0, s_reg});
                mul_b = $signed({3'd0, q_reg});
                dst_next = DST_B3;
                state_next = ST_N_E1;
            end
            ST_N_E1:
            begin
                mul_a = $signed({2'd0, b1_reg});
                mul_b = $signed({{4{d1_reg[31]}}, d1_reg});
                dst_next = DST_ESET;
                state_next = ST_N_E2;
            end
            ST_N_E2:
            begin
                mul_a = $signed({2'd0, b2_reg});
                mul_b = $signed({{2{d2[33]}}, d2});
                dst_next = DST_EADD;
                state_next = ST_N_E3;
            end
            ST_N_E3:
            begin
                mul_a = $signed({2'd0, b3_reg});
                mul_b = $signed({{3{dx_reg[32]}}, dx_reg});
                dst_next = DST_EADD;
                state_next = ST_N_E4;
            end
            ST_N_E4:
            begin
                mul_a = $signed({11'd0, t_reg});
                mul_b = $signed({{3{dx_reg[32]}}, dx_reg});
                dst_next = DST_ESUB;
                state_next = ST_N_S1;
            end
            ST_N_S1:
            begin
                mul_a = $signed({1'b0, a0_reg});
                mul_b = $signed({{4{d1_reg[31]}}, d1_reg});
                dst_next = DST_SSET;
                state_next = ST_N_S2;
            end
            ST_N_S2:
            begin
                mul_a = $signed({1'b0, a1_reg});
                mul_b = $signed({dd[34], dd});
                dst_next = DST_SADD;
                state_next = ST_N_S3;
            end
            ST_N_S3:
            begin
                mul_a = $signed({1'b0, a2_reg});
                mul_b = $signed({{3{nih[32]}}, nih});
                dst_next = DST_SADD;
                state_next = ST_N_WT;
            end
            ST_N_WT:
            begin
                state_next = ST_N_MAG;
            end
            ST_N_MAG:
            begin
                state_next = ST_N_TST;
            end
            ST_N_TST:
            begin
                if ($signed(emag_reg) < tol || smag_reg < SLOPE_MIN)
                begin
                    state_next = ST_V_MM;
                end
                else
                begin
                    state_next = ST_N_D0;
                end
            end
            ST_N_D0:
            begin
                state_next = (emag_reg >= {smag_reg[62:0], 1'b0}) ? ST_N_UPD : ST_N_DIV;
            end
            ST_N_DIV:
            begin
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = ST_N_UPD;
                end
            end
            ST_N_UPD:
            begin
                state_next = (cnt_reg == CW'(NEWTON_STEPS - 1)) ? ST_V_MM : ST_N_MM;
            end
            ST_V_W0:
            begin
                mul_a = $signed({10'd0, ms});
                mul_b = $signed({3'd0, p_reg});
                dst_next = DST_W0;
                state_next = ST_V_W1;
            end
            ST_V_W1:
            begin
                mul_a = $signed({8'd0, s3});
                mul_b = $signed({3'd0, p_reg});
                dst_next = DST_W1;
                state_next = ST_V_W2;
            end
            ST_V_W2:
            begin
                mul_a = $signed({8'd0, ms3});
                mul_b = $signed({3'd0, q_reg});
                dst_next = DST_W2;
                state_next = ST_V_W3;
            end
            ST_V_W3:
            begin
                mul_a = $signed({10'd0, s_reg});
                mul_b = $signed({3'd0, q_reg});
                dst_next = DST_W3;
                state_next = ST_V_A0;
            end
            ST_V_A0:
            begin
                mul_a = $signed({{8{v0_reg[18]}}, v0_reg});
                mul_b = $signed({3'd0, w0_reg});
                dst_next = DST_ESET;
                state_next = ST_V_A1;
            end
            ST_V_A1:
            begin
                mul_a = $signed({{8{c1_reg[18]}}, c1_reg});
                mul_b = $signed({3'd0, w1_reg});
                dst_next = DST_EADD;
                state_next = ST_V_A2;
            end
            ST_V_A2:
            begin
                mul_a = $signed({{8{c2_reg[18]}}, c2_reg});
                mul_b = $signed({3'd0, w2_reg});
                dst_next = DST_EADD;
                state_next = ST_V_A3;
            end
            ST_V_A3:
            begin
                mul_a = $signed({{8{v3_reg[18]}}, v3_reg});
                mul_b = $signed({3'd0, w3_reg});
                dst_next = DST_EADD;
                state_next = ST_V_WT;
            end
            ST_V_WT:
            begin
                state_next = ST_V_FIN;
            end
            ST_V_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dst_reg       <= DST_NONE;
            cnt_reg       <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dst_reg   <= dst_next;
            if (in_fire)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_N_UPD)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (state_reg == ST_N_DIV)
            begin
                div_cnt_reg <= div_cnt_reg + 4'd1;
            end
            else
            begin
                div_cnt_reg <= '0;
            end
            if (state_reg == ST_V_FIN && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (in_fire)
        begin
            t_reg  <= s_axis_tdata[15:0];
            s_reg  <= {1'b0, s_axis_tdata[15:0]};
            dx_reg <= $signed({1'b0, s_axis_tdata[79:48]}) - $signed({1'b0, s_axis_tdata[47:16]});
            d1_reg <= $signed(s_axis_tdata[111:80]);
            ih_reg <= $signed(s_axis_tdata[143:112]);
            v0_reg <= $signed({2'd0, s_axis_tdata[160:144]});
            v3_reg <= $signed({2'd0, s_axis_tdata[177:161]});
            c1_reg <= $signed({2'd0, s_axis_tdata[160:144]})
                    + $signed({s_axis_tdata[195], s_axis_tdata[195:178]});
            c2_reg <= $signed({2'd0, s_axis_tdata[177:161]})
                    + $signed({s_axis_tdata[213], s_axis_tdata[213:196]});
        end

        case (dst_reg)
            DST_P:
            begin
                p_reg  <= prod_reg[32:0];
                a0_reg <= three_p[33:8];
            end
            DST_Q:
            begin
                q_reg  <= prod_reg[32:0];
                a2_reg <= three_p[33:8];
            end
            DST_R:    a1_reg    <= six_r[33:8];
            DST_B1:   b1_reg    <= prod_reg[48:24];
            DST_B2:   b2_reg    <= prod_reg[48:24];
            DST_B3:   b3_reg    <= prod_reg[48:24];
            DST_ESET: err_reg   <= prod_ext;
            DST_EADD: err_reg   <= err_reg + prod_ext;
            DST_ESUB: err_reg   <= err_reg - prod_sh8;
            DST_SSET: slope_reg <= prod_ext;
            DST_SADD: slope_reg <= slope_reg + prod_ext;
            DST_W0:   w0_reg    <= prod_reg[48:16];
            DST_W1:   w1_reg    <= prod_reg[48:16];
            DST_W2:   w2_reg    <= prod_reg[48:16];
            DST_W3:   w3_reg    <= prod_reg[48:16];
            default:
            begin
            end
        endcase

        if (state_reg == ST_N_MAG)
        begin
            emag_reg <= err_reg[63] ? 64'(-err_reg) : 64'(err_reg);
            smag_reg <= slope_reg[63] ? 64'(-slope_reg) : 64'(slope_reg);
            neg_reg  <= err_reg[63] ^ slope_reg[63];
        end

        if (state_reg == ST_N_D0)
        begin
            two_reg  <= (emag_reg >= {smag_reg[62:0], 1'b0});
            qi_reg   <= (emag_reg >= smag_reg);
            rem_reg  <= (emag_reg >= smag_reg) ? emag_reg - smag_reg : emag_reg;
            frac_reg <= '0;
        end
        else if (state_reg == ST_N_DIV)
        begin
            if (rem2 >= smag_reg)
            begin
                rem_reg  <= rem2 - smag_reg;
                frac_reg <= {frac_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem2;
                frac_reg <= {frac_reg[14:0], 1'b0};
            end
        end

        if (state_reg == ST_N_UPD)
        begin
            if (s_upd < 0)
            begin
                s_reg <= '0;
            end
            else if (s_upd > $signed({2'd0, ONE_Q16}))
            begin
                s_reg <= ONE_Q16;
            end
            else
            begin
                s_reg <= s_upd[16:0];
            end
        end

        if (state_reg == ST_V_FIN && (!out_valid_reg || m_axis_tready))
        begin
            solved_reg <= s_reg;
            if (vq < VAL_MIN)
            begin
                value_reg <= VAL_MIN[18:0];
            end
            else if (vq > VAL_MAX)
            begin
                value_reg <= VAL_MAX[18:0];
            end
            else
            begin
                value_reg <= vq[18:0];
            end
        end
    end

endmodule

FILE: rtl/bezval_chk.sv
// port checker for the bezier segment value unit and its bind
module bezval_chk
    import bezval_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a taken request keeps the block busy, with s_axis_tready low after it
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("request taken while busy");

    // solved parameter stays in [0,1]
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[35:19] <= 17'd65536)
        else $error("solved parameter out of range");

    // padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:36] == '0)
        else $error("result padding not zero");

endmodule

bind bezier_segment_value_at_x bezval_chk u_chk (.*);

FILE: dv/tb_top.sv
// self-checking testbench for the bezier segment value unit
module tb_top;
    import bezval_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  N_RANDOM    = 1140;
    localparam int  HOLD_CYCLES = 1500;
    localparam int  TAIL_CYCLES = 450;
    localparam longint MAX_CYCLES = 3000000;

    typedef struct packed {
        logic signed [17:0] in_hv;
        logic signed [17:0] out_hv;
        logic [16:0]        end_v;
        logic [16:0]        start_v;
        logic signed [31:0] in_hb;
        logic signed [31:0] out_hb;
        logic [31:0]        end_b;
        logic [31:0]        start_b;
        logic [15:0]        frac_t;
    } segment_t;

    typedef struct {
        segment_t    seg;
        bit          typed;
        logic [18:0] cv;
        logic [16:0] sp;
    } seg_row_t;

    typedef struct {
        logic [18:0] cv;
        logic [16:0] sp;
    } curve_point_t;

    logic            clk;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;

    bit           drv_typed;
    curve_point_t drv_point;
    bit           no_idle;
    int           accepted_cnt;
    int           result_cnt;
    int           error_cnt;
    curve_point_t point_q[$];

    bezier_segment_value_at_x dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // newton solve of the x cubic, then the value cubic at the solved parameter
    function automatic curve_point_t solve_segment(input segment_t g);
        curve_point_t res;
        longint dd, d1, d2, tgt, tol, s, v0, v3, c1, c2;
        longint b1, b2, b3, a0, a1, a2, err, slope, delta, v;
        logic [63:0] us, ums, ue, usl, w0, w1, w2, w3;
        logic [127:0] q;
        dd  = longint'({32'd0, g.end_b}) - longint'({32'd0, g.start_b});
        d1  = longint'(g.out_hb);
        d2  = dd + longint'(g.in_hb);
        tgt = longint'({48'd0, g.frac_t}) * dd * 256;
        tol = (dd + 65536) * 17;
        s   = longint'({48'd0, g.frac_t});
        v0  = longint'({47'd0, g.start_v});
        v3  = longint'({47'd0, g.end_v});
        c1  = v0 + longint'(g.out_hv);
        c2  = v3 + longint'(g.in_hv);
        for (int i = 0; i < 12; i++)
        begin
            us    = s;
            ums   = 64'd65536 - us;
            b1    = longint'((64'd3 * ums * ums * us) >> 24);
            b2    = longint'((64'd3 * ums * us * us) >> 24);
            b3    = longint'((us * us * us) >> 24);
            err   = b1 * d1 + b2 * d2 + b3 * dd - tgt;
            ue    = (err < 0) ? -err : err;
            if (longint'(ue) < tol)
                break;
            a0    = longint'((64'd3 * ums * ums) >> 8);
            a1    = longint'((64'd6 * ums * us) >> 8);
            a2    = longint'((64'd3 * us * us) >> 8);
            slope = a0 * d1 + a1 * (d2 - d1) + a2 * (dd - d2);
            usl   = (slope < 0) ? -slope : slope;
            if (usl < SLOPE_MIN)
                break;
            if (ue >= 2 * usl)
                delta = 131072;
            else
            begin
                q     = ({64'd0, ue} << 16) / {64'd0, usl};
                delta = longint'(q[63:0]);
            end
            if ((err < 0) != (slope < 0))
                delta = -delta;
            s = s - delta;
            if (s < 0)
                s = 0;
            if (s > 65536)
                s = 65536;
        end
        us  = s;
        ums = 64'd65536 - us;
        w0  = (ums * ums * ums) >> 16;
        w1  = (64'd3 * ums * ums * us) >> 16;
        w2  = (64'd3 * ums * us * us) >> 16;
        w3  = (us * us * us) >> 16;
        v   = longint'(w0) * v0 + longint'(w1) * c1 + longint'(w2) * c2 + longint'(w3) * v3;
        v   = (v + ROUND_HALF) >>> 32;
        if (v < VAL_MIN)
            v = VAL_MIN;
        if (v > VAL_MAX)
            v = VAL_MAX;
        res.cv = v[18:0];
        res.sp = s[16:0];
        return res;
    endfunction

    function automatic segment_t mk_seg(input logic [15:0] t, input logic [31:0] x0,
                                        input logic [31:0] x3, input logic [31:0] ohb,
                                        input logic [31:0] ihb, input logic [16:0] v0,
                                        input logic [16:0] v3, input logic [17:0] ohv,
                                        input logic [17:0] ihv);
        segment_t g;
        g.frac_t  = t;
        g.start_b = x0;
        g.end_b   = x3;
        g.out_hb  = ohb;
        g.in_hb   = ihb;
        g.start_v = v0;
        g.end_v   = v3;
        g.out_hv  = ohv;
        g.in_hv   = ihv;
        return g;
    endfunction

    function automatic segment_t rand_segment();
        segment_t g;
        longint span, x0;
        if ($urandom_range(0, 99) < 20)
        begin
            g.frac_t  = 16'($urandom);
            g.start_b = $urandom;
            g.end_b   = $urandom;
            g.out_hb  = $urandom;
            g.in_hb   = $urandom;
            g.start_v = 17'($urandom);
            g.end_v   = 17'($urandom);
            g.out_hv  = 18'($urandom);
            g.in_hv   = 18'($urandom);
            return g;
        end
        if ($urandom_range(0, 9) == 0)
            span = longint'($urandom_range(1, 32'hFFFF_FFFF));
        else
            span = longint'($urandom_range(1, 32'h0040_0000));
        x0 = longint'($urandom_range(0, 32'hFFFF_FFFF - span[31:0]));
        g.frac_t  = 16'($urandom);
        g.start_b = x0[31:0];
        g.end_b   = x0[31:0] + span[31:0];
        g.out_hb  = $urandom_range(0, span[31:0]);
        g.in_hb   = 32'(-$signed({1'b0, $urandom_range(0, span[31:0])}));
        if ($urandom_range(0, 4) == 0)
        begin
            g.out_hb = g.out_hb * 2;
            g.in_hb  = -g.out_hb;
        end
        g.start_v = 17'($urandom_range(0, 65536));
        g.end_v   = 17'($urandom_range(0, 65536));
        g.out_hv  = 18'($signed($urandom_range(0, 131072)) - 65536);
        g.in_hv   = 18'($signed($urandom_range(0, 131072)) - 65536);
        return g;
    endfunction

    task automatic send_segment(input segment_t g, input bit typed, input curve_point_t pt);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, g};
        drv_typed     <= typed;
        drv_point     <= pt;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic idle_gap();
        if (!no_idle && $urandom_range(0, 99) < 30)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
        end
    endtask

    seg_row_t     plan[$];
    curve_point_t nopt;

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        drv_typed     = 1'b0;
        drv_point     = '{cv: '0, sp: '0};
        nopt          = '{cv: '0, sp: '0};
        no_idle       = 1'b0;
        rst_n         = 1'b0;
        repeat (5)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // t zero: solve stays at s zero and the value is the start value
        plan.push_back('{mk_seg(16'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 17'd65536, 17'd0,
                                18'd0, 18'd0), 1'b1, 19'd65536, 17'd0});
        // zero length segment
        plan.push_back('{mk_seg(16'd0, 32'd1000, 32'd1000, 32'd0, 32'd0, 17'd0, 17'd65536,
                                18'd0, 18'd0), 1'b1, 19'd0, 17'd0});
        // flat slope with a tolerance that never passes
        plan.push_back('{mk_seg(16'd0, 32'd65536, 32'd0, 32'd0, 32'd65536, 17'd12345, 17'd0,
                                18'd0, 18'd0), 1'b1, 19'd12345, 17'd0});
        plan.push_back('{mk_seg(16'hFFFF, 32'd0, 32'h0010_0000, 32'h0005_5555, -32'sh0005_5555,
                                17'd0, 17'd65536, 18'd21845, -18'sd21845), 1'b0, '0, '0});
        plan.push_back('{mk_seg(16'h8000, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                17'd65536, 17'd0, 18'd65536, -18'sd65536), 1'b0, '0, '0});
        plan.push_back('{mk_seg(16'h4000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 17'd100, 17'd200,
                                18'd0, 18'd0), 1'b0, '0, '0});
        plan.push_back('{mk_seg(16'h1234, 32'd5000, 32'd5000, 32'h0001_0000, -32'sh0001_0000,
                                17'd0, 17'd65536, 18'd0, 18'd0), 1'b0, '0, '0});
        plan.push_back('{mk_seg(16'hC000, 32'd0, 32'h0004_0000, 32'h0004_0000, 32'd0,
                                17'h1FFFF, 17'h1FFFF, 18'h1FFFF, 18'h1FFFF), 1'b0, '0, '0});
        plan.push_back('{mk_seg(16'h6000, 32'd0, 32'h0004_0000, 32'd0, -32'sh0004_0000,
                                17'd0, 17'd0, 18'h20000, 18'h20000), 1'b0, '0, '0});
        plan.push_back('{mk_seg(16'h0001, 32'h8000_0000, 32'h8000_0001, 32'd0, 32'd0,
                                17'd65536, 17'd65536, -18'sd65536, 18'd65536), 1'b0, '0, '0});
        plan.push_back('{mk_seg(16'hFFFF, 32'h1000_0000, 32'h2000_0000, -32'sh1000_0000,
                                32'h1000_0000, 17'd30000, 17'd40000, 18'd1000, -18'sd1000),
                         1'b0, '0, '0});
        for (int i = 0; i < 4; i++)
            plan.push_back('{rand_segment(), 1'b0, '0, '0});

        foreach (plan[i])
        begin
            send_segment(plan[i].seg, plan[i].typed, '{cv: plan[i].cv, sp: plan[i].sp});
            idle_gap();
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_idle = (i >= 400 && i < 560);
            if (i == 700)
            begin
                s_axis_tvalid <= 1'b0;
                wait (point_q.size() == 0);
                @(negedge clk);
            end
            send_segment(rand_segment(), 1'b0, nopt);
            idle_gap();
        end
        s_axis_tvalid <= 1'b0;
        no_idle = 1'b0;

        wait (point_q.size() == 0);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        $display("%0d segments solved, %0d results checked, %0d mismatches",
                 accepted_cnt, result_cnt, error_cnt);
        $display("covered t and beat extremes, reversed and zero length segments, flat slope");
        if (error_cnt == 0 && point_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // receiver: random stalls, a quiet stretch, and one long hold-off
    initial
    begin
        int hold_left;
        bit hold_done;
        hold_left     = 0;
        hold_done     = 1'b0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && accepted_cnt >= 200)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (no_idle)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 99) >= 30);
        end
    end

    always @(posedge clk)
    begin
        curve_point_t got, want;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (drv_typed)
                point_q.push_back(drv_point);
            else
                point_q.push_back(solve_segment(segment_t'(s_axis_tdata[IN_W-3:0])));
            accepted_cnt++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.cv = m_axis_tdata[18:0];
            got.sp = m_axis_tdata[35:19];
            result_cnt++;
            if (point_q.size() == 0)
            begin
                $display("%0t: unexpected result cv=%0d sp=%0d", $time,
                         $signed(got.cv), got.sp);
                error_cnt++;
            end
            else
            begin
                want = point_q.pop_front();
                if (got.cv !== want.cv)
                begin
                    $display("%0t: curve_value expected %0d got %0d", $time,
                             $signed(want.cv), $signed(got.cv));
                    error_cnt++;
                end
                if (got.sp !== want.sp)
                begin
                    $display("%0t: solved_param expected %0d got %0d", $time,
                             want.sp, got.sp);
                    error_cnt++;
                end
            end
        end
    end

    initial
    begin
        longint cycles;
        cycles = 0;
        while (cycles < MAX_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycles);
        $display("Some tests failed");
        $finish;
    end

endmodule
